/* sv/cds_pkg.sv */
// Shared types, constants and calendar arithmetic for the date stepper.
package cds_pkg;

  // Field widths
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned YearW   = 14;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned DiffW   = 23;
  localparam int unsigned SerialW = 23;

  localparam int unsigned MaxYearDefault = 9999;

  typedef logic [MonthW-1:0]       month_t;
  typedef logic [DayW-1:0]         day_t;
  typedef logic [YearW-1:0]        year_t;
  typedef logic [WdayW-1:0]        wday_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic [SerialW-1:0]      serial_t;

  typedef enum logic [1:0] {
    OpSet  = 2'd0,
    OpFwd  = 2'd1,
    OpBack = 2'd2,
    OpDiff = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadMonth  = 2'd1,
    StBadDay    = 2'd2,
    StYearRange = 2'd3
  } status_e;

  // Stored date after an operation, with its status
  typedef struct packed {
    month_t  month;
    day_t    day;
    year_t   year;
    status_e status;
  } step_res_t;

  localparam month_t MonthJan = 4'd1;
  localparam month_t MonthFeb = 4'd2;
  localparam month_t MonthDec = 4'd12;
  localparam day_t   DayFirst = 5'd1;
  localparam day_t   DayLast  = 5'd31;
  localparam day_t   DayLeap  = 5'd29;
  localparam year_t  YearMin  = 14'd1;
  localparam year_t  ResetYear = 14'd2000;

  // Day count saturation limits and the reciprocal of 365 (scaled by 2^32)
  localparam logic [DiffW-1:0] SatPos = 23'd4194303;
  localparam logic [DiffW-1:0] SatNeg = 23'd4194304;
  localparam logic [23:0]      Recip365 = 24'd11767034;

  // y / 100 by reciprocal multiply, exact for all 14-bit y
  function automatic logic [7:0] div100(input year_t y);
    logic [26:0] p;
    p = 27'(y) * 27'd5243;
    return p[26:19];
  endfunction

  // y % 100
  function automatic logic [6:0] rem100(input year_t y);
    logic [YearW-1:0] t;
    t = y - year_t'(div100(y)) * year_t'(100);
    return t[6:0];
  endfunction

  // Gregorian leap rule
  function automatic logic is_leap(input year_t y);
    logic [7:0] q;
    logic [6:0] r;
    q = div100(y);
    r = rem100(y);
    return ((y[1:0] == 2'd0) && (r != 7'd0)) || ((r == 7'd0) && (q[1:0] == 2'd0));
  endfunction

  // Month length; zero for a month code outside 1..12
  function automatic day_t days_in(input month_t m, input logic leap);
    day_t d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // Days in the year before the first of month m
  function automatic logic [8:0] month_before(input month_t m);
    logic [8:0] v;
    unique case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Month code of the century weekday formula, leap adjusted for Jan and Feb
  function automatic logic [2:0] month_code(input month_t m, input logic leap);
    logic [2:0] c;
    unique case (m)
      4'd1:    c = leap ? 3'd6 : 3'd0;
      4'd2:    c = leap ? 3'd2 : 3'd3;
      4'd3:    c = 3'd3;
      4'd4:    c = 3'd6;
      4'd5:    c = 3'd1;
      4'd6:    c = 3'd4;
      4'd7:    c = 3'd6;
      4'd8:    c = 3'd2;
      4'd9:    c = 3'd5;
      4'd10:   c = 3'd0;
      4'd11:   c = 3'd3;
      4'd12:   c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Day serial number of a valid date (year at least 1)
  function automatic serial_t serial(input month_t m, input day_t d, input year_t y);
    year_t      p;
    logic [7:0] q;
    logic [11:0] leaps;
    p = (m <= MonthFeb) ? y - YearMin : y;
    q = div100(p);
    leaps = 12'(p[YearW-1:2]) - 12'(q) + 12'(q[7:2]);
    return serial_t'(y) * serial_t'(365) + serial_t'(leaps) + serial_t'(month_before(m))
           + serial_t'(d);
  endfunction

  // Weekday, 0 Sunday to 6 Saturday
  function automatic wday_t weekday_of(input month_t m, input day_t d, input year_t y);
    logic [7:0]  q;
    logic [6:0]  r;
    logic [2:0]  cent;
    logic [7:0]  s;
    logic [15:0] p;
    logic [7:0]  t;
    q = div100(y);
    r = rem100(y);
    cent = {2'(2'd3 - q[1:0]), 1'b0};
    s = 8'(cent) + 8'(r) + 8'(r[6:2]) + 8'(month_code(m, is_leap(y))) + 8'(d);
    // s / 7 by reciprocal multiply, exact for s below 224
    p = 16'(s) * 16'd293;
    t = s - 8'(p[15:11]) * 8'd7;
    return t[WdayW-1:0];
  endfunction

  // Argument check: month first, then day, then year
  function automatic status_e check_date(input month_t m, input day_t d, input year_t y,
                                         input year_t max_year);
    status_e st;
    if (m < MonthJan || m > MonthDec) begin
      st = StBadMonth;
    end else if (d < DayFirst || d > days_in(m, is_leap(y))) begin
      st = StBadDay;
    end else if (y < YearMin || y > max_year) begin
      st = StYearRange;
    end else begin
      st = StOk;
    end
    return st;
  endfunction

endpackage

/* sv/cds_stepper.sv */
// Next stored date and status for one operation.
module cds_stepper #(
  parameter int unsigned MaxYear = cds_pkg::MaxYearDefault
) (
  input  cds_pkg::op_e       op_i,
  input  logic               step_unit_i,
  input  cds_pkg::month_t    cur_month_i,
  input  cds_pkg::day_t      cur_day_i,
  input  cds_pkg::year_t     cur_year_i,
  input  cds_pkg::month_t    arg_month_i,
  input  cds_pkg::day_t      arg_day_i,
  input  cds_pkg::year_t     arg_year_i,
  input  cds_pkg::status_e   arg_status_i,
  output cds_pkg::step_res_t res_o
);
  import cds_pkg::*;

  localparam year_t MaxYearV = year_t'(MaxYear);

  logic   leap_cur, leap_up, leap_dn, on_feb29;
  year_t  year_up, year_dn;
  day_t   dim_cur, dim_prev;
  month_t month_prev;

  // Leap flags of this, next and previous year
  assign year_up    = cur_year_i + YearMin;
  assign year_dn    = cur_year_i - YearMin;
  assign leap_cur   = is_leap(cur_year_i);
  assign leap_up    = is_leap(year_up);
  assign leap_dn    = is_leap(year_dn);
  assign on_feb29   = (cur_month_i == MonthFeb) && (cur_day_i == DayLeap);
  assign month_prev = cur_month_i - MonthJan;
  assign dim_cur    = days_in(cur_month_i, leap_cur);
  assign dim_prev   = days_in(month_prev, leap_cur);

  always_comb begin
    res_o.month  = cur_month_i;
    res_o.day    = cur_day_i;
    res_o.year   = cur_year_i;
    res_o.status = StOk;
    unique case (op_i)
      OpSet: begin
        res_o.status = arg_status_i;
        if (arg_status_i == StOk) begin
          res_o.month = arg_month_i;
          res_o.day   = arg_day_i;
          res_o.year  = arg_year_i;
        end
      end
      OpFwd: begin
        if (step_unit_i) begin
          if (cur_year_i >= MaxYearV) begin
            res_o.status = StYearRange;
          end else if (on_feb29 && !leap_up) begin
            res_o.status = StBadDay;
          end else begin
            res_o.year = year_up;
          end
        end else if (cur_day_i < dim_cur) begin
          res_o.day = cur_day_i + DayFirst;
        end else if (cur_month_i < MonthDec) begin
          res_o.month = cur_month_i + MonthJan;
          res_o.day   = DayFirst;
        end else if (cur_year_i >= MaxYearV) begin
          res_o.status = StYearRange;
        end else begin
          res_o.year  = year_up;
          res_o.month = MonthJan;
          res_o.day   = DayFirst;
        end
      end
      OpBack: begin
        if (step_unit_i) begin
          if (cur_year_i <= YearMin) begin
            res_o.status = StYearRange;
          end else if (on_feb29 && !leap_dn) begin
            res_o.status = StBadDay;
          end else begin
            res_o.year = year_dn;
          end
        end else if (cur_day_i > DayFirst) begin
          res_o.day = cur_day_i - DayFirst;
        end else if (cur_month_i > MonthJan) begin
          res_o.month = month_prev;
          res_o.day   = dim_prev;
        end else if (cur_year_i <= YearMin) begin
          res_o.status = StYearRange;
        end else begin
          res_o.year  = year_dn;
          res_o.month = MonthDec;
          res_o.day   = DayLast;
        end
      end
      OpDiff: begin
        res_o.status = arg_status_i;
      end
      default: begin
        res_o.status = StOk;
      end
    endcase
  end

endmodule

/* sv/calendar_date_stepper.sv */
// Top level of the Gregorian date stepper: pipeline, stored date and result register.
//
// Keeps one Gregorian date (reset: Jan 1 2000) and takes one transaction per cycle
// while the output is not stalled: set, step forward, step back or difference;
// step_unit selects days or years. Every transaction yields exactly one result,
// in order. The stored date is updated in the third stage, so back-to-back
// transactions each see the date left by the one before. A stalled output holds
// the whole pipeline. The configuration write is accepted at any time but must
// only be issued while no transaction is in flight.
module calendar_date_stepper #(
  parameter int unsigned MaxYear = cds_pkg::MaxYearDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_step_unit_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cds_pkg::op_e      operation_i,
  input  cds_pkg::month_t   arg_month_i,
  input  cds_pkg::day_t     arg_day_i,
  input  cds_pkg::year_t    arg_year_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cds_pkg::month_t   cur_month_out_o,
  output cds_pkg::day_t     cur_day_out_o,
  output cds_pkg::year_t    cur_year_out_o,
  output cds_pkg::wday_t    weekday_o,
  output cds_pkg::diff_t    difference_o,
  output cds_pkg::status_e  status_o
);
  import cds_pkg::*;

  localparam year_t MaxYearV = year_t'(MaxYear);

  logic en;
  logic step_unit_q;

  // Stage A: accepted transaction
  logic   a_valid_q;
  op_e    a_op_q;
  month_t a_month_q;
  day_t   a_day_q;
  year_t  a_year_q;

  // Stage B: checked argument and its serial
  logic    b_valid_q;
  op_e     b_op_q;
  month_t  b_month_q;
  day_t    b_day_q;
  year_t   b_year_q;
  status_e b_status_q;
  serial_t b_serial_q;

  // Stored date and stage C
  month_t    cur_month_q;
  day_t      cur_day_q;
  year_t     cur_year_q;
  step_res_t step_res;
  logic      c_valid_q;
  op_e       c_op_q;
  status_e   c_status_q;
  serial_t   c_arg_serial_q;

  // Stage D: serial and weekday of stored date
  logic    d_valid_q;
  logic    d_diff_q;
  status_e d_status_q;
  month_t  d_month_q;
  day_t    d_day_q;
  year_t   d_year_q;
  wday_t   d_wday_q;
  serial_t d_cur_serial_q;
  serial_t d_arg_serial_q;

  // Stage E: saturated day count as sign and magnitude
  logic             e_valid_q;
  logic             e_diff_q;
  status_e          e_status_q;
  month_t           e_month_q;
  day_t             e_day_q;
  year_t            e_year_q;
  wday_t            e_wday_q;
  logic             e_neg_q;
  logic [DiffW-1:0] e_mag_q;

  logic             out_valid_q;
  month_t           out_month_q;
  day_t             out_day_q;
  year_t            out_year_q;
  wday_t            out_wday_q;
  diff_t            out_diff_q;
  status_e          out_status_q;

  logic signed [SerialW:0] diff_raw;
  logic [SerialW:0]        diff_abs;
  logic [DiffW-1:0]        mag_sat;
  logic [DiffW-1:0]        quot;
  logic [DiffW-1:0]        mag_sel;
  logic [46:0]             quot_prod;
  diff_t                   diff_res;

  // Whole pipeline moves together unless a result waits
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_unit_q <= 1'b0;
    end else if (cfg_valid_i) begin
      step_unit_q <= cfg_step_unit_i;
    end
  end

  // Valid bits of all stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      d_valid_q   <= c_valid_q;
      e_valid_q   <= d_valid_q;
      out_valid_q <= e_valid_q;
    end
  end

  // Stage A and B payload: capture, then check argument and take its serial
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q     <= operation_i;
      a_month_q  <= arg_month_i;
      a_day_q    <= arg_day_i;
      a_year_q   <= arg_year_i;
      b_op_q     <= a_op_q;
      b_month_q  <= a_month_q;
      b_day_q    <= a_day_q;
      b_year_q   <= a_year_q;
      b_status_q <= check_date(a_month_q, a_day_q, a_year_q, MaxYearV);
      b_serial_q <= serial(a_month_q, a_day_q, a_year_q);
    end
  end

  cds_stepper #(
    .MaxYear(MaxYear)
  ) u_stepper (
    .op_i        (b_op_q),
    .step_unit_i (step_unit_q),
    .cur_month_i (cur_month_q),
    .cur_day_i   (cur_day_q),
    .cur_year_i  (cur_year_q),
    .arg_month_i (b_month_q),
    .arg_day_i   (b_day_q),
    .arg_year_i  (b_year_q),
    .arg_status_i(b_status_q),
    .res_o       (step_res)
  );

  // Stored date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_month_q <= MonthJan;
      cur_day_q   <= DayFirst;
      cur_year_q  <= ResetYear;
    end else if (en && b_valid_q) begin
      cur_month_q <= step_res.month;
      cur_day_q   <= step_res.day;
      cur_year_q  <= step_res.year;
    end
  end

  // Stage C payload; the stored date itself stands for this stage's date
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_op_q         <= b_op_q;
      c_status_q     <= step_res.status;
      c_arg_serial_q <= b_serial_q;
    end
  end

  // Stage D: serial and weekday of the stored date
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_diff_q       <= (c_op_q == OpDiff) && (c_status_q == StOk);
      d_status_q     <= c_status_q;
      d_month_q      <= cur_month_q;
      d_day_q        <= cur_day_q;
      d_year_q       <= cur_year_q;
      d_wday_q       <= weekday_of(cur_month_q, cur_day_q, cur_year_q);
      d_cur_serial_q <= serial(cur_month_q, cur_day_q, cur_year_q);
      d_arg_serial_q <= c_arg_serial_q;
    end
  end

  // Day count, saturated, as sign and magnitude
  always_comb begin
    diff_raw = $signed({1'b0, d_cur_serial_q}) - $signed({1'b0, d_arg_serial_q});
    diff_abs = diff_raw[SerialW] ? (SerialW+1)'(-diff_raw) : diff_raw;
    if (diff_raw[SerialW]) begin
      mag_sat = (diff_abs > (SerialW+1)'(SatNeg)) ? SatNeg : diff_abs[DiffW-1:0];
    end else begin
      mag_sat = (diff_abs > (SerialW+1)'(SatPos)) ? SatPos : diff_abs[DiffW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_diff_q   <= d_diff_q;
      e_status_q <= d_status_q;
      e_month_q  <= d_month_q;
      e_day_q    <= d_day_q;
      e_year_q   <= d_year_q;
      e_wday_q   <= d_wday_q;
      e_neg_q    <= d_diff_q && diff_raw[SerialW];
      e_mag_q    <= d_diff_q ? mag_sat : '0;
    end
  end

  // Days, or in years mode magnitude / 365 by reciprocal multiply, then restore the sign
  always_comb begin
    quot_prod = 47'(e_mag_q) * 47'(Recip365);
    quot      = DiffW'(quot_prod[46:32]);
    mag_sel   = step_unit_q ? quot : e_mag_q;
    diff_res  = e_neg_q ? diff_t'(-mag_sel) : diff_t'(mag_sel);
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_month_q  <= e_month_q;
      out_day_q    <= e_day_q;
      out_year_q   <= e_year_q;
      out_wday_q   <= e_wday_q;
      out_diff_q   <= e_diff_q ? diff_res : '0;
      out_status_q <= e_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cur_month_out_o = out_month_q;
  assign cur_day_out_o   = out_day_q;
  assign cur_year_out_o  = out_year_q;
  assign weekday_o       = out_wday_q;
  assign difference_o    = out_diff_q;
  assign status_o        = out_status_q;

endmodule

/* dv/calendar_date_stepper_tb.sv */
// Self-checking testbench for the calendar date stepper: directed table, random phases, scoreboard.
module calendar_date_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cds_pkg::*;

  localparam int MaxYear    = cds_pkg::MaxYearDefault;
  localparam int PipeDepth  = 5;
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 200;
  localparam int CycleLimit = 400000;

  // One expected result
  typedef struct packed {
    month_t  month;
    day_t    day;
    year_t   year;
    wday_t   wday;
    diff_t   diff;
    status_e status;
  } date_result_t;

  // Directed row: step unit, transaction, and the result read off by hand
  typedef struct packed {
    logic    unit;
    op_e     op;
    month_t  m;
    day_t    d;
    year_t   y;
    month_t  em;
    day_t    ed;
    year_t   ey;
    diff_t   ediff;
    status_e est;
  } row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cfg_valid_i = 1'b0;
  logic    cfg_ready_o;
  logic    cfg_step_unit_i = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  op_e     operation_i = OpSet;
  month_t  arg_month_i = '0;
  day_t    arg_day_i = '0;
  year_t   arg_year_i = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b1;
  month_t  cur_month_out_o;
  day_t    cur_day_out_o;
  year_t   cur_year_out_o;
  wday_t   weekday_o;
  diff_t   difference_o;
  status_e status_o;

  // Predictor state
  int cal_month = 1;
  int cal_day = 1;
  int cal_year = 2000;
  bit years_mode = 1'b0;

  date_result_t pending_dates[$];
  row_t         steps_table[$];
  date_result_t got_front;

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  unit_writes = 0;
  int  cycles = 0;
  int  stall_left = 0;
  bit  no_idle = 1'b0;
  int  op_seen[4];
  int  st_seen[4];

  calendar_date_stepper #(
    .MaxYear(MaxYear)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_step_unit_i(cfg_step_unit_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .arg_month_i    (arg_month_i),
    .arg_day_i      (arg_day_i),
    .arg_year_i     (arg_year_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cur_month_out_o(cur_month_out_o),
    .cur_day_out_o  (cur_day_out_o),
    .cur_year_out_o (cur_year_out_o),
    .weekday_o      (weekday_o),
    .difference_o   (difference_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap_year(input int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int month_days(input int m, input int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int days_before(input int m);
    case (m)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  // Absolute day number; Jan and Feb count leap days up to the year before
  function automatic int day_count(input int m, input int d, input int y);
    int p;
    int leaps;
    p = (m <= 2) ? y - 1 : y;
    leaps = (y == 0) ? 0 : (p / 4 - p / 100 + p / 400);
    return y * 365 + leaps + days_before(m) + d;
  endfunction

  // Century-formula weekday, 0 is Sunday
  function automatic int weekday_num(input int m, input int d, input int y);
    int code;
    case (m)
      1, 10:    code = 0;
      2, 3, 11: code = 3;
      4, 7:     code = 6;
      5:        code = 1;
      6:        code = 4;
      8:        code = 2;
      default:  code = 5;
    endcase
    if (is_leap_year(y)) begin
      if (m == 1) code = 6;
      else if (m == 2) code = 2;
    end
    return ((3 - (y / 100) % 4) * 2 + y % 100 + (y % 100) / 4 + code + d) % 7;
  endfunction

  // Argument check order: month, then day, then year
  function automatic status_e check_arg(input int m, input int d, input int y);
    if (m < 1 || m > 12) return StBadMonth;
    if (d < 1 || d > month_days(m, y)) return StBadDay;
    if (y < 1 || y > MaxYear) return StYearRange;
    return StOk;
  endfunction

  // Year step refuses to land on Feb 29 of a common year
  function automatic status_e year_move(input int ny);
    if (cal_month == 2 && cal_day == 29 && !is_leap_year(ny)) return StBadDay;
    cal_year = ny;
    return StOk;
  endfunction

  function automatic status_e step_forward();
    if (years_mode) begin
      if (cal_year >= MaxYear) return StYearRange;
      return year_move(cal_year + 1);
    end
    if (cal_day < month_days(cal_month, cal_year)) begin
      cal_day++;
    end else if (cal_month < 12) begin
      cal_month++;
      cal_day = 1;
    end else begin
      if (cal_year >= MaxYear) return StYearRange;
      cal_year++;
      cal_month = 1;
      cal_day = 1;
    end
    return StOk;
  endfunction

  function automatic status_e step_backward();
    if (years_mode) begin
      if (cal_year <= 1) return StYearRange;
      return year_move(cal_year - 1);
    end
    if (cal_day > 1) begin
      cal_day--;
    end else if (cal_month > 1) begin
      cal_month--;
      cal_day = month_days(cal_month, cal_year);
    end else begin
      if (cal_year <= 1) return StYearRange;
      cal_year--;
      cal_month = 12;
      cal_day = 31;
    end
    return StOk;
  endfunction

  // Apply one transaction to the stored date and build its result
  function automatic date_result_t advance_date(input op_e op, input int m, input int d,
                                                input int y);
    date_result_t r;
    int           delta;
    delta = 0;
    case (op)
      OpSet: begin
        r.status = check_arg(m, d, y);
        if (r.status == StOk) begin
          cal_month = m;
          cal_day = d;
          cal_year = y;
        end
      end
      OpFwd:  r.status = step_forward();
      OpBack: r.status = step_backward();
      default: begin
        r.status = check_arg(m, d, y);
        if (r.status == StOk) begin
          delta = day_count(cal_month, cal_day, cal_year) - day_count(m, d, y);
          if (delta > 4194303) delta = 4194303;
          if (delta < -4194304) delta = -4194304;
          if (years_mode) delta = delta / 365;
        end
      end
    endcase
    r.month = month_t'(cal_month);
    r.day = day_t'(cal_day);
    r.year = year_t'(cal_year);
    r.wday = wday_t'(weekday_num(cal_month, cal_day, cal_year));
    r.diff = diff_t'(delta);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_row(input bit unit, input op_e op, input int m, input int d,
                                  input int y, input int em, input int ed, input int ey,
                                  input int ediff, input status_e est);
    row_t r;
    r.unit = unit;
    r.op = op;
    r.m = month_t'(m);
    r.d = day_t'(d);
    r.y = year_t'(y);
    r.em = month_t'(em);
    r.ed = day_t'(ed);
    r.ey = year_t'(ey);
    r.ediff = diff_t'(ediff);
    r.est = est;
    steps_table.push_back(r);
  endfunction

  // Valid date, biased toward year ends, month ends, centuries and leap days
  task automatic pick_date(output int m, output int d, output int y);
    int r;
    r = $urandom_range(9);
    case (r)
      0:       y = ($urandom_range(1)) ? $urandom_range(1, 2) : MaxYear - $urandom_range(1);
      1:       y = 100 * $urandom_range(1, MaxYear / 100);
      2:       y = 4 * $urandom_range(1, MaxYear / 4);
      default: y = $urandom_range(1, MaxYear);
    endcase
    m = $urandom_range(1, 12);
    r = $urandom_range(9);
    if (r == 0) begin
      m = 2;
      y = 4 * $urandom_range(1, MaxYear / 4);
      if (!is_leap_year(y)) y = 2000;
      d = 29;
    end else if (r == 1) begin
      m = ($urandom_range(1)) ? 12 : 1;
      d = (m == 12) ? 31 : 1;
    end else if (r <= 4) begin
      d = month_days(m, y);
    end else if (r == 5) begin
      d = 1;
    end else begin
      d = $urandom_range(1, month_days(m, y));
    end
  endtask

  task automatic noise_fields(output int m, output int d, output int y);
    m = $urandom_range(0, 15);
    d = $urandom_range(0, 31);
    y = $urandom_range(0, 16383);
  endtask

  // Drive one transaction, wait for acceptance, queue its expected result
  task automatic drive_item(input op_e op, input int m, input int d, input int y,
                            input bit typed, input date_result_t want);
    date_result_t pred;
    if (!no_idle && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    arg_month_i <= month_t'(m);
    arg_day_i <= day_t'(d);
    arg_year_i <= year_t'(y);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = advance_date(op, m, d, y);
    if (typed) begin
      pred.month = want.month;
      pred.day = want.day;
      pred.year = want.year;
      pred.diff = want.diff;
      pred.status = want.status;
    end
    pending_dates.push_back(pred);
    op_seen[op]++;
    items_sent++;
  endtask

  // Step unit changes only with the pipeline empty
  task automatic write_step_unit(input bit u);
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_step_unit_i <= u;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    years_mode = u;
    unit_writes++;
  endtask

  task automatic report_field(input string name, input int got, input int want);
    $display("MISMATCH t=%0t result %0d %s: got %0d, expected %0d",
             $time, results_seen, name, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready bursts, then comparison against the oldest entry
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni || no_idle) begin
      out_ready_i <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_dates.size() == 0) begin
        report_field("unexpected transaction, queue empty", int'(status_o), -1);
      end else begin
        got_front = pending_dates.pop_front();
        st_seen[got_front.status]++;
        if (cur_month_out_o !== got_front.month)
          report_field("month", int'(cur_month_out_o), int'(got_front.month));
        if (cur_day_out_o !== got_front.day)
          report_field("day", int'(cur_day_out_o), int'(got_front.day));
        if (cur_year_out_o !== got_front.year)
          report_field("year", int'(cur_year_out_o), int'(got_front.year));
        if (weekday_o !== got_front.wday)
          report_field("weekday", int'(weekday_o), int'(got_front.wday));
        if (difference_o !== got_front.diff)
          report_field("difference", int'(difference_o), int'(got_front.diff));
        if (status_o !== got_front.status)
          report_field("status", int'(status_o), int'(got_front.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, pending_dates.size());
      $display("calendar_date_stepper verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int           m;
    int           d;
    int           y;
    int           r;
    int           run_len;
    int           target;
    op_e          op;
    row_t         row;
    date_result_t want;

    for (int i = 0; i < 4; i++) begin
      op_seen[i] = 0;
      st_seen[i] = 0;
    end

    // Directed rows, day steps first, then year steps
    add_row(0, OpDiff, 1, 1, 2000,      1, 1, 2000, 0, StOk);
    add_row(0, OpSet, 0, 1, 2000,       1, 1, 2000, 0, StBadMonth);
    add_row(0, OpSet, 15, 31, 9999,     1, 1, 2000, 0, StBadMonth);
    add_row(0, OpSet, 2, 30, 2000,      1, 1, 2000, 0, StBadDay);
    add_row(0, OpSet, 1, 0, 2000,       1, 1, 2000, 0, StBadDay);
    add_row(0, OpSet, 2, 29, 1900,      1, 1, 2000, 0, StBadDay);
    add_row(0, OpSet, 1, 1, 0,          1, 1, 2000, 0, StYearRange);
    add_row(0, OpSet, 12, 31, 16383,    1, 1, 2000, 0, StYearRange);
    add_row(0, OpSet, 12, 31, 9999,     12, 31, 9999, 0, StOk);
    add_row(0, OpFwd, 0, 0, 0,          12, 31, 9999, 0, StYearRange);
    add_row(0, OpSet, 1, 1, 1,          1, 1, 1, 0, StOk);
    add_row(0, OpBack, 15, 31, 16383,   1, 1, 1, 0, StYearRange);
    add_row(0, OpFwd, 0, 0, 0,          1, 2, 1, 0, StOk);
    add_row(0, OpDiff, 12, 31, 9999,    1, 2, 1, -3652057, StOk);
    add_row(0, OpSet, 12, 31, 1999,     12, 31, 1999, 0, StOk);
    add_row(0, OpFwd, 0, 0, 0,          1, 1, 2000, 0, StOk);
    add_row(0, OpSet, 3, 1, 1900,       3, 1, 1900, 0, StOk);
    add_row(0, OpBack, 0, 0, 0,         2, 28, 1900, 0, StOk);
    add_row(1, OpDiff, 13, 1, 2000,     2, 28, 1900, 0, StBadMonth);
    add_row(1, OpSet, 2, 29, 2000,      2, 29, 2000, 0, StOk);
    add_row(1, OpFwd, 0, 0, 0,          2, 29, 2000, 0, StBadDay);
    add_row(1, OpBack, 0, 0, 0,         2, 29, 2000, 0, StBadDay);
    add_row(1, OpSet, 1, 1, 1,          1, 1, 1, 0, StOk);
    add_row(1, OpBack, 0, 0, 0,         1, 1, 1, 0, StYearRange);
    add_row(1, OpDiff, 12, 31, 9999,    1, 1, 1, -10005, StOk);
    add_row(1, OpSet, 6, 15, 9999,      6, 15, 9999, 0, StOk);
    add_row(1, OpFwd, 0, 0, 0,          6, 15, 9999, 0, StYearRange);

    // Reset
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Step unit written explicitly after reset
    write_step_unit(1'b0);

    // Directed table
    foreach (steps_table[i]) begin
      row = steps_table[i];
      if (row.unit != years_mode) write_step_unit(row.unit);
      want = '0;
      want.month = row.em;
      want.day = row.ed;
      want.year = row.ey;
      want.diff = row.ediff;
      want.status = row.est;
      drive_item(row.op, int'(row.m), int'(row.d), int'(row.y), 1'b1, want);
    end

    // Random phases, step unit alternating, last phase without idling
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_step_unit(ph[0]);
      no_idle = (ph == NumPhases - 1);
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 22) begin
          pick_date(m, d, y);
          drive_item(OpSet, m, d, y, 1'b0, '0);
        end else if (r < 27) begin
          noise_fields(m, d, y);
          drive_item(OpSet, m, d, y, 1'b0, '0);
        end else if (r < 77) begin
          // runs of steps walk across month and year boundaries
          op = (r < 52) ? OpFwd : OpBack;
          run_len = $urandom_range(1, 6);
          repeat (run_len) begin
            noise_fields(m, d, y);
            drive_item(op, m, d, y, 1'b0, '0);
          end
        end else if (r < 93) begin
          pick_date(m, d, y);
          drive_item(OpDiff, m, d, y, 1'b0, '0);
        end else begin
          noise_fields(m, d, y);
          drive_item(OpDiff, m, d, y, 1'b0, '0);
        end
      end
    end

    // Drain
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);

    $display("Covered %0d transactions: %0d set, %0d forward, %0d back, %0d difference; %0d unit writes",
             items_sent, op_seen[OpSet], op_seen[OpFwd], op_seen[OpBack], op_seen[OpDiff],
             unit_writes);
    $display("Statuses checked: ok %0d, bad month %0d, bad day %0d, year range %0d; %0d errors",
             st_seen[StOk], st_seen[StBadMonth], st_seen[StBadDay], st_seen[StYearRange], errors);
    if (errors == 0) begin
      $display("calendar_date_stepper verification clean");
    end else begin
      $display("calendar_date_stepper verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/cds_pkg.sv
sv/cds_stepper.sv
sv/calendar_date_stepper.sv
dv/calendar_date_stepper_tb.sv
